### src/fraction_add_sub_reduce_assert.svh
// assertion macros for the fraction add/sub/reduce checker
`ifndef FRACTION_ADD_SUB_REDUCE_ASSERT_SVH
`define FRACTION_ADD_SUB_REDUCE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define FAS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fraction_add_sub_reduce: assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define FAS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fraction_add_sub_reduce: assertion failed");

`endif

### src/fas_pkg.sv
// shared types and constants for the fraction add/sub/reduce block
package fas_pkg;

  localparam int OPERAND_WIDTH_DEF = 16;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_LOAD,
    ST_REM_GO,
    ST_REM_WAIT,
    ST_QN_GO,
    ST_QN_WAIT,
    ST_QD_GO,
    ST_QD_WAIT
  } fas_state_t;

endpackage

### src/fas_div.sv
// shared unsigned restoring divider, one quotient bit per cycle
module fas_div
  import fas_pkg::*;
#(
  parameter int MAG_WIDTH = 2 * OPERAND_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [MAG_WIDTH-1:0] dividend,
  input  logic [MAG_WIDTH-1:0] divisor,
  output logic                 done,
  output logic [MAG_WIDTH-1:0] quotient,
  output logic [MAG_WIDTH-1:0] remainder
);

  localparam int CntW = $clog2(MAG_WIDTH);
  localparam logic [CntW-1:0] LastCnt = CntW'(MAG_WIDTH - 1);

  logic                 busy_r;
  logic                 done_r;
  logic [CntW-1:0]      cnt_r;
  logic [MAG_WIDTH-1:0] rem_r;
  logic [MAG_WIDTH-1:0] quo_r;
  logic [MAG_WIDTH-1:0] dvs_r;

  logic [MAG_WIDTH:0]   shifted;
  logic [MAG_WIDTH:0]   diff;
  logic                 fits;
  logic [MAG_WIDTH-1:0] rem_nxt;
  logic [MAG_WIDTH-1:0] quo_nxt;

  // one shift-subtract step
  always_comb begin
    shifted = {rem_r, quo_r[MAG_WIDTH-1]};
    diff    = shifted - {1'b0, dvs_r};
    fits    = !diff[MAG_WIDTH];
    rem_nxt = fits ? diff[MAG_WIDTH-1:0] : shifted[MAG_WIDTH-1:0];
    quo_nxt = {quo_r[MAG_WIDTH-2:0], fits};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LastCnt) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: quotient shifts in where the dividend shifts out
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

### src/fraction_add_sub_reduce.sv
// Fraction add/subtract with Euclid reduction on one shared iterative divider.
// After accept the sequencer runs MUL0-MUL2 and LOAD, then k >= 1 Euclid remainder
// steps (each one divider pass), then the numerator and denominator quotient passes.
// One word at a time: busy drops in the cycle out_valid shows, so a new word is only
// taken in or after that cycle; the shared divider makes one quotient bit per cycle.
// Reset (rst_n low, synchronous) returns to idle and clears out_valid; no stall.
module fraction_add_sub_reduce
  import fas_pkg::*;
#(
  parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_req_type,
  input  logic signed [OPERAND_WIDTH-1:0] in_a_num,
  input  logic signed [OPERAND_WIDTH-1:0] in_a_den,
  input  logic signed [OPERAND_WIDTH-1:0] in_b_num,
  input  logic signed [OPERAND_WIDTH-1:0] in_b_den,
  output logic                            out_valid,
  output logic signed [2*OPERAND_WIDTH-1:0] out_res_num,
  output logic signed [2*OPERAND_WIDTH-2:0] out_res_den
);

  localparam int W  = OPERAND_WIDTH;
  localparam int MW = 2 * W;       // magnitude width
  localparam int NW = 2 * W + 1;   // signed working width

  fas_state_t state_r, state_nxt;

  logic                 sub_r;
  logic signed [W-1:0]  an_r, ad_r, bn_r, bd_r;
  logic signed [MW-1:0] prod_r;
  logic signed [NW-1:0] acc_r;
  logic signed [NW-1:0] x_r, y_r;
  logic signed [MW-1:0]   res_num_r;
  logic signed [MW-2:0]   res_den_r;
  logic                 out_valid_r;

  logic                 accept;
  logic signed [W-1:0]  mul_a, mul_b;
  logic signed [MW-1:0] prod_c;
  logic signed [NW-1:0] prod_ext;
  logic signed [NW-1:0] dvd_val;
  logic                 dvd_neg, dvs_neg;
  logic signed [NW-1:0] dvd_abs, dvs_abs;
  logic                 div_start;
  logic                 div_done;
  logic [MW-1:0]        div_quo, div_rem;
  logic signed [NW-1:0] rem_s, quo_s;

  assign accept   = start && (state_r == ST_IDLE);
  assign prod_ext = {prod_r[MW-1], prod_r};

  // shared multiplier, registered into prod_r
  assign prod_c = mul_a * mul_b;

  // divider operands: divisor is always the current Euclid divisor
  always_comb begin
    case (state_r)
      ST_QN_GO, ST_QN_WAIT: dvd_val = acc_r;
      ST_QD_GO, ST_QD_WAIT: dvd_val = prod_ext;
      default:              dvd_val = x_r;
    endcase
    dvd_neg = dvd_val[NW-1];
    dvs_neg = y_r[NW-1];
    dvd_abs = dvd_neg ? -dvd_val : dvd_val;
    dvs_abs = dvs_neg ? -y_r : y_r;
  end

  // signed results, truncated toward zero
  always_comb begin
    rem_s = dvd_neg ? -NW'({1'b0, div_rem}) : NW'({1'b0, div_rem});
    quo_s = (dvd_neg ^ dvs_neg) ? -NW'({1'b0, div_quo}) : NW'({1'b0, div_quo});
  end

  fas_div #(
    .MAG_WIDTH(MW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (dvd_abs[MW-1:0]),
    .divisor   (dvs_abs[MW-1:0]),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (start) state_nxt = ST_MUL0;
      ST_MUL0:     state_nxt = ST_MUL1;
      ST_MUL1:     state_nxt = ST_MUL2;
      ST_MUL2:     state_nxt = ST_LOAD;
      ST_LOAD:     state_nxt = ST_REM_GO;
      ST_REM_GO:   state_nxt = ST_REM_WAIT;
      ST_REM_WAIT: begin
        if (div_done) state_nxt = (rem_s == '0) ? ST_QN_GO : ST_REM_GO;
      end
      ST_QN_GO:    state_nxt = ST_QN_WAIT;
      ST_QN_WAIT:  if (div_done) state_nxt = ST_QD_GO;
      ST_QD_GO:    state_nxt = ST_QD_WAIT;
      ST_QD_WAIT:  if (div_done) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    busy      = (state_r != ST_IDLE);
    div_start = 1'b0;
    mul_a     = an_r;
    mul_b     = bd_r;
    case (state_r)
      ST_MUL1: begin
        mul_a = ad_r;
        mul_b = bn_r;
      end
      ST_MUL2: begin
        mul_a = ad_r;
        mul_b = bd_r;
      end
      ST_REM_GO, ST_QN_GO, ST_QD_GO: div_start = 1'b1;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_QD_WAIT) && div_done;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          sub_r <= in_req_type;
          an_r  <= in_a_num;
          ad_r  <= (in_a_den == '0) ? W'(1) : in_a_den;
          bn_r  <= in_b_num;
          bd_r  <= (in_b_den == '0) ? W'(1) : in_b_den;
        end
      end
      ST_MUL0: prod_r <= prod_c;
      ST_MUL1: begin
        acc_r  <= prod_ext;
        prod_r <= prod_c;
      end
      ST_MUL2: begin
        acc_r  <= sub_r ? (acc_r - prod_ext) : (acc_r + prod_ext);
        prod_r <= prod_c;
      end
      ST_LOAD: begin
        x_r <= acc_r;
        y_r <= prod_ext;
      end
      ST_REM_WAIT: begin
        if (div_done && (rem_s != '0)) begin
          x_r <= y_r;
          y_r <= rem_s;
        end
      end
      ST_QN_WAIT: if (div_done) res_num_r <= quo_s[MW-1:0];
      ST_QD_WAIT: if (div_done) res_den_r <= quo_s[MW-2:0];
      default: ;
    endcase
  end

  assign out_valid   = out_valid_r;
  assign out_res_num = res_num_r;
  assign out_res_den = res_den_r;

endmodule

### src/fas_checker.sv
// port-level checker for fraction_add_sub_reduce, bound to the top level
`include "fraction_add_sub_reduce_assert.svh"

module fas_checker
  import fas_pkg::*;
#(
  parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            start,
  input logic                            busy,
  input logic                            out_valid,
  input logic signed [2*OPERAND_WIDTH-2:0] out_res_den
);

  // an accepted word keeps the block busy
  `FAS_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  // a result never comes the cycle right after accept
  `FAS_ASSERT_NEXT(a_no_early_result, start && !busy, !out_valid)
  // busy drops exactly when the result word shows
  `FAS_ASSERT_NOW(a_done_with_result, $fell(busy), out_valid)
  // one result word per item, and a reduced denominator is never zero
  `FAS_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid)
  `FAS_ASSERT_NOW(a_den_nonzero, out_valid, out_res_den != '0)

endmodule

bind fraction_add_sub_reduce fas_checker #(
  .OPERAND_WIDTH(OPERAND_WIDTH)
) u_fas_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .out_valid   (out_valid),
  .out_res_den (out_res_den)
);

### verif/testbench.sv
// self-checking testbench for the fraction add/sub/reduce block with an internal gcd predictor
module testbench;
  import fas_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int OPW        = OPERAND_WIDTH_DEF;
  localparam int QUIET_MAX  = 20000;
  localparam int DRAIN_WAIT = 2000;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_SUB = 1'b1;

  localparam logic signed [OPW-1:0] OPND_MAX  = 16'sh7fff;
  localparam logic signed [OPW-1:0] OPND_MIN  = -16'sh7fff;
  localparam logic signed [OPW-1:0] OPND_WRAP = 16'sh8000;

  typedef struct packed {
    logic                  sub;
    logic signed [OPW-1:0] a_num;
    logic signed [OPW-1:0] a_den;
    logic signed [OPW-1:0] b_num;
    logic signed [OPW-1:0] b_den;
  } fraction_pair_t;

  typedef struct packed {
    logic signed [2*OPW-1:0] num;
    logic signed [2*OPW-2:0] den;
  } reduced_frac_t;

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic                    in_req_type;
  logic signed [OPW-1:0]   in_a_num;
  logic signed [OPW-1:0]   in_a_den;
  logic signed [OPW-1:0]   in_b_num;
  logic signed [OPW-1:0]   in_b_den;
  logic                    out_valid;
  logic signed [2*OPW-1:0] out_res_num;
  logic signed [2*OPW-2:0] out_res_den;

  reduced_frac_t pending_sums[$];
  int            mismatches;
  int            quiet_cycles;

  fraction_add_sub_reduce #(
    .OPERAND_WIDTH(OPW)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req_type(in_req_type),
    .in_a_num   (in_a_num),
    .in_a_den   (in_a_den),
    .in_b_num   (in_b_num),
    .in_b_den   (in_b_den),
    .out_valid  (out_valid),
    .out_res_num(out_res_num),
    .out_res_den(out_res_den)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // cross-multiply, then divide both terms by the last euclid divisor
  function automatic reduced_frac_t reduce_fraction_sum(fraction_pair_t p);
    longint        an, ad, bn, bd, n, d, x, y, r;
    reduced_frac_t q;
    an = longint'(p.a_num);
    ad = longint'(p.a_den);
    bn = longint'(p.b_num);
    bd = longint'(p.b_den);
    if (ad == 0) ad = 1;
    if (bd == 0) bd = 1;
    n = (p.sub == OP_SUB) ? an * bd - ad * bn : an * bd + ad * bn;
    d = ad * bd;
    // remainder truncates toward zero, same sign rules as signed %
    x = n;
    y = d;
    r = x % y;
    while (r != 0) begin
      x = y;
      y = r;
      r = x % y;
    end
    n = n / y;
    d = d / y;
    q.num = n[2*OPW-1:0];
    q.den = d[2*OPW-2:0];
    return q;
  endfunction

  function automatic fraction_pair_t pair(logic sub, logic signed [OPW-1:0] an,
                                          logic signed [OPW-1:0] ad,
                                          logic signed [OPW-1:0] bn,
                                          logic signed [OPW-1:0] bd);
    fraction_pair_t p;
    p.sub   = sub;
    p.a_num = an;
    p.a_den = ad;
    p.b_num = bn;
    p.b_den = bd;
    return p;
  endfunction

  // mix of extremes, small values and shared factors so reduction does real work
  function automatic logic signed [OPW-1:0] pick_operand();
    logic signed [OPW-1:0] v;
    case ($urandom_range(0, 11))
      0: v = '0;
      1: v = OPND_WRAP;
      2: v = $urandom_range(0, 1) ? OPND_MAX : OPND_MIN;
      3, 4: v = OPW'($urandom_range(1, 40));
      5, 6: v = OPW'($urandom_range(1, 12) * $urandom_range(1, 2000));
      default: v = OPW'($urandom());
    endcase
    if ($urandom_range(0, 1) && v != OPND_WRAP) v = -v;
    return v;
  endfunction

  function automatic fraction_pair_t random_pair();
    fraction_pair_t p;
    p.sub   = 1'($urandom_range(0, 1));
    p.a_num = pick_operand();
    p.a_den = pick_operand();
    // occasionally repeat or negate the first fraction so sums cancel or reduce hard
    case ($urandom_range(0, 9))
      0: begin
        p.b_num = p.a_num;
        p.b_den = p.a_den;
      end
      1: begin
        p.b_num = -p.a_num;
        p.b_den = p.a_den;
      end
      default: begin
        p.b_num = pick_operand();
        p.b_den = pick_operand();
      end
    endcase
    return p;
  endfunction

  // present one word; start drops at random during the wait, garbage rides on the
  // fields while it is low
  task automatic send_pair(fraction_pair_t p, int idle_pct);
    bit go;
    bit taken;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      go = ($urandom_range(0, 99) >= idle_pct);
      start <= go;
      if (go) begin
        in_req_type <= p.sub;
        in_a_num    <= p.a_num;
        in_a_den    <= p.a_den;
        in_b_num    <= p.b_num;
        in_b_den    <= p.b_den;
      end else begin
        in_req_type <= 1'($urandom_range(0, 1));
        in_a_num    <= OPW'($urandom());
        in_a_den    <= OPW'($urandom());
        in_b_num    <= OPW'($urandom());
        in_b_den    <= OPW'($urandom());
      end
      @(posedge clk);
      taken = go && !busy;
    end
  endtask

  // extremes of every operand, including the wrapping most negative value
  task automatic test_field_extremes();
    send_pair(pair(OP_ADD, OPND_MAX, OPND_MAX, OPND_MAX, OPND_MAX), 0);
    send_pair(pair(OP_SUB, OPND_MIN, OPND_MAX, OPND_MAX, OPND_MIN), 0);
    send_pair(pair(OP_ADD, OPND_MAX, 16'sd1, OPND_MAX, 16'sd1), 0);
    send_pair(pair(OP_SUB, OPND_MIN, 16'sd1, OPND_MAX, 16'sd1), 0);
    send_pair(pair(OP_ADD, OPND_WRAP, OPND_WRAP, OPND_WRAP, OPND_WRAP), 0);
    send_pair(pair(OP_SUB, OPND_WRAP, 16'sd1, OPND_MAX, 16'sd1), 0);
    send_pair(pair(OP_ADD, OPND_WRAP, OPND_WRAP, OPND_WRAP, 16'sd1), 0);
    send_pair(pair(OP_ADD, OPND_WRAP, 16'sd1, OPND_WRAP, 16'sd1), 0);
    send_pair(pair(OP_SUB, OPND_WRAP, OPND_MAX, OPND_MAX, OPND_WRAP), 0);
  endtask

  // zero denominators stand for one
  task automatic test_zero_denominators();
    send_pair(pair(OP_ADD, 16'sd3, 16'sd0, 16'sd5, 16'sd7), 0);
    send_pair(pair(OP_SUB, 16'sd3, 16'sd4, -16'sd5, 16'sd0), 0);
    send_pair(pair(OP_ADD, -16'sd9, 16'sd0, 16'sd2, 16'sd0), 0);
    send_pair(pair(OP_SUB, 16'sd0, 16'sd0, 16'sd0, 16'sd0), 0);
  endtask

  // numerator sums of zero come out as 0/1
  task automatic test_zero_sums();
    send_pair(pair(OP_SUB, 16'sd1, 16'sd2, 16'sd1, 16'sd2), 0);
    send_pair(pair(OP_ADD, 16'sd0, 16'sd5, 16'sd0, -16'sd7), 0);
    send_pair(pair(OP_ADD, 16'sd3, -16'sd4, 16'sd3, 16'sd4), 0);
    send_pair(pair(OP_SUB, OPND_WRAP, OPND_MAX, OPND_WRAP, OPND_MAX), 0);
  endtask

  // both operations with mixed signs, negative divisors and common factors
  task automatic test_operations();
    send_pair(pair(OP_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd3), 0);
    send_pair(pair(OP_SUB, 16'sd1, 16'sd2, 16'sd1, 16'sd3), 0);
    send_pair(pair(OP_ADD, 16'sd1, -16'sd2, 16'sd1, -16'sd3), 0);
    send_pair(pair(OP_SUB, -16'sd6, 16'sd4, 16'sd9, -16'sd12), 0);
    send_pair(pair(OP_ADD, 16'sd21, 16'sd6, 16'sd35, 16'sd10), 0);
    send_pair(pair(OP_SUB, 16'sd17711, 16'sd28657, 16'sd10946, 16'sd17711), 0);
  endtask

  task automatic test_random_traffic(int count, int idle_pct);
    repeat (count) send_pair(random_pair(), idle_pct);
  endtask

  // result check, prediction on accept, and the quiet-cycle count
  always @(posedge clk) begin
    reduced_frac_t want;
    if (rst_n) begin
      quiet_cycles = quiet_cycles + 1;
      if (out_valid) begin
        quiet_cycles = 0;
        if (pending_sums.size() == 0) begin
          $display("%0t: unexpected result num=%0d den=%0d", $time, out_res_num, out_res_den);
          mismatches = mismatches + 1;
        end else begin
          want = pending_sums.pop_front();
          if (out_res_num !== want.num) begin
            $display("%0t: res_num expected %0d actual %0d", $time, want.num, out_res_num);
            mismatches = mismatches + 1;
          end
          if (out_res_den !== want.den) begin
            $display("%0t: res_den expected %0d actual %0d", $time, want.den, out_res_den);
            mismatches = mismatches + 1;
          end
        end
      end
      if (start && !busy) begin
        quiet_cycles = 0;
        pending_sums.push_back(reduce_fraction_sum(pair(in_req_type, in_a_num, in_a_den,
                                                        in_b_num, in_b_den)));
      end
    end
  end

  // watchdog
  initial begin
    while (quiet_cycles < QUIET_MAX) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  // sequence
  initial begin
    mismatches   = 0;
    quiet_cycles = 0;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_req_type  = OP_ADD;
    in_a_num     = '0;
    in_a_den     = '0;
    in_b_num     = '0;
    in_b_den     = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    test_field_extremes();
    test_zero_denominators();
    test_zero_sums();
    test_operations();
    test_random_traffic(180, 20);
    test_random_traffic(180, 84);
    test_random_traffic(190, 0);

    @(negedge clk);
    start <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
